### src/smpq_pkg.sv
package smpq_pkg;

	// Queue depth and the widths that follow from it.
	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Field widths of the stream transactions.
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;
	localparam int RES_W    = VAL_W + STATUS_W + COUNT_W + 1;
	localparam int OUT_W    = ((RES_W + 7) / 8) * 8;
	localparam int IN_W     = ((VAL_W + 7) / 8) * 8;

	// Bit positions of the result fields inside the output tdata.
	localparam int STATUS_LSB = VAL_W;
	localparam int COUNT_LSB  = VAL_W + STATUS_W;
	localparam int EMPTY_BIT  = VAL_W + STATUS_W + COUNT_W;

	// Operation codes carried in the input tuser.
	localparam logic KIND_ENQ = 1'b0;
	localparam logic KIND_DEQ = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Access to the entry memory: one write request and one read request.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [VAL_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// One finished operation.
	typedef struct packed {
		logic               empty;
		logic [COUNT_W-1:0] count;
		status_t            status;
		logic [VAL_W-1:0]   value;
	} result_t;

	// Physical slot of a logical position counted from the head of the ring.
	function automatic logic [ADDR_W-1:0] ring_addr(input logic [ADDR_W-1:0] head,
			input logic [ADDR_W-1:0] pos);
		logic [ADDR_W:0] sum;
		sum = {1'b0, head} + {1'b0, pos};
		if (sum >= (ADDR_W + 1)'(CAPACITY)) begin
			sum = sum - (ADDR_W + 1)'(CAPACITY);
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage

### src/smpq_ram.sv
module smpq_ram (
	input  logic                     clk,
	input  smpq_pkg::mem_req_t       req,
	output logic [smpq_pkg::VAL_W-1:0] rd_data
);
	import smpq_pkg::*;

	logic [VAL_W-1:0] mem [CAPACITY];

	// Single write port.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// Registered read port; read during write of the same slot returns old data.
	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_data <= mem[req.raddr];
		end
	end

endmodule

### src/smpq_ctrl.sv
module smpq_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         in_kind,
	input  logic signed [smpq_pkg::VAL_W-1:0] in_value,
	input  logic signed [smpq_pkg::VAL_W-1:0] rd_data,
	output smpq_pkg::mem_req_t           mem_req,
	output logic                         res_valid,
	output smpq_pkg::result_t            res,
	input  logic                         res_ready
);
	import smpq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ENQ_CMP,
		S_ENQ_LAST,
		S_DEQ_RD,
		S_RESP
	} state_t;

	state_t                   state_q;
	logic [ADDR_W-1:0]        head_q;
	logic [CNT_W-1:0]         held_q;
	logic [ADDR_W-1:0]        pos_q;
	logic signed [VAL_W-1:0]  val_q;
	result_t                  res_q;

	logic                     accept;
	logic                     is_full;
	logic                     is_empty;
	logic                     greater;
	logic [CNT_W-1:0]         held_inc;
	logic [CNT_W-1:0]         held_dec;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign is_full   = (held_q == CNT_W'(CAPACITY));
	assign is_empty  = (held_q == '0);
	assign greater   = (val_q > rd_data);
	assign held_inc  = held_q + CNT_W'(1);
	assign held_dec  = held_q - CNT_W'(1);
	assign res_valid = (state_q == S_RESP);
	assign res       = res_q;

	// Memory accesses: each compare step writes one slot and, while the walk goes on, prefetches the next.
	always_comb begin
		mem_req = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && in_kind == KIND_ENQ && !is_full) begin
					if (is_empty) begin
						mem_req.we    = 1'b1;
						mem_req.waddr = head_q;
						mem_req.wdata = in_value;
					end else begin
						mem_req.re    = 1'b1;
						mem_req.raddr = ring_addr(head_q, ADDR_W'(held_dec));
					end
				end else if (accept && in_kind == KIND_DEQ && !is_empty) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = head_q;
				end
			end
			S_ENQ_CMP: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = ring_addr(head_q, pos_q);
				if (greater) begin
					mem_req.wdata = rd_data;
					if (pos_q > ADDR_W'(1)) begin
						mem_req.re    = 1'b1;
						mem_req.raddr = ring_addr(head_q, pos_q - ADDR_W'(2));
					end
				end else begin
					mem_req.wdata = val_q;
				end
			end
			S_ENQ_LAST: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = head_q;
				mem_req.wdata = val_q;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	// Sequencer, ring pointers and the staged result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			held_q  <= '0;
			pos_q   <= '0;
			val_q   <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q.value <= '0;
						val_q       <= in_value;
						if (in_kind == KIND_ENQ) begin
							if (is_full) begin
								res_q.status <= ST_FULL;
								res_q.count  <= COUNT_W'(held_q);
								res_q.empty  <= 1'b0;
								state_q      <= S_RESP;
							end else if (is_empty) begin
								held_q       <= held_inc;
								res_q.status <= ST_OK;
								res_q.count  <= COUNT_W'(held_inc);
								res_q.empty  <= 1'b0;
								state_q      <= S_RESP;
							end else begin
								pos_q   <= ADDR_W'(held_q);
								state_q <= S_ENQ_CMP;
							end
						end else begin
							if (is_empty) begin
								res_q.status <= ST_EMPTY;
								res_q.count  <= '0;
								res_q.empty  <= 1'b1;
								state_q      <= S_RESP;
							end else begin
								state_q <= S_DEQ_RD;
							end
						end
					end
				end
				S_ENQ_CMP: begin
					if (greater) begin
						pos_q <= pos_q - ADDR_W'(1);
						if (pos_q == ADDR_W'(1)) begin
							state_q <= S_ENQ_LAST;
						end
					end else begin
						held_q       <= held_inc;
						res_q.status <= ST_OK;
						res_q.count  <= COUNT_W'(held_inc);
						res_q.empty  <= 1'b0;
						state_q      <= S_RESP;
					end
				end
				S_ENQ_LAST: begin
					held_q       <= held_inc;
					res_q.status <= ST_OK;
					res_q.count  <= COUNT_W'(held_inc);
					res_q.empty  <= 1'b0;
					state_q      <= S_RESP;
				end
				S_DEQ_RD: begin
					head_q       <= ring_addr(head_q, ADDR_W'(1));
					held_q       <= held_dec;
					res_q.value  <= rd_data;
					res_q.status <= ST_OK;
					res_q.count  <= COUNT_W'(held_dec);
					res_q.empty  <= (held_dec == '0);
					state_q      <= S_RESP;
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### src/sorted_max_priority_queue.sv
// Channel  Direction  tdata fields (lsb first)                      tuser
// s_axis   in         value[31:0], zero pad to 32                  kind[0]
// m_axis   out        value_out[31:0], status[33:32], count[40:34],  -
//                     empty_res[41], zero pad to 48
//
// Entries sit in a ring in one memory with a registered read port.
// Enqueue: into an empty queue the value is written directly; otherwise the
// tail is read and each held value smaller than the new one moves back a slot,
// up to the front. Dequeue reads the head; full and empty reports need no read.
// A result waits in the output register while the next transaction is taken.
// Reset empties the queue at once; memory contents are never cleared.
module sorted_max_priority_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [smpq_pkg::IN_W-1:0]     s_axis_tdata,  // value
	input  logic [0:0]                    s_axis_tuser,  // kind
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [smpq_pkg::OUT_W-1:0]    m_axis_tdata   // value_out, status, count, empty_res
);
	import smpq_pkg::*;

	mem_req_t                mem_req;
	logic signed [VAL_W-1:0] rd_data;
	logic                    res_valid;
	logic                    res_ready;
	result_t                 res;
	logic                    out_valid_q;
	logic [OUT_W-1:0]        out_data_q;

	smpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser[0]),
		.in_value  ($signed(s_axis_tdata[VAL_W-1:0])),
		.rd_data   (rd_data),
		.mem_req   (mem_req),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	smpq_ram u_ram (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	// Output register: loads whenever it is empty or being drained.
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= OUT_W'(res);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

### src/smpq_check.sv
module smpq_check (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tvalid,
	input logic                       s_axis_tready,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [smpq_pkg::OUT_W-1:0] m_axis_tdata
);
	import smpq_pkg::*;

	logic [STATUS_W-1:0] st;
	logic [COUNT_W-1:0]  cnt;

	assign st  = m_axis_tdata[COUNT_LSB-1:STATUS_LSB];
	assign cnt = m_axis_tdata[EMPTY_BIT-1:COUNT_LSB];

	// A stalled result transaction holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// The empty flag agrees with the count.
	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[EMPTY_BIT] == (cnt == '0)))
		else $error("empty flag disagrees with count");

	// Only a successful operation carries a value, and no unused status code appears.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st != ST_OK |->
			m_axis_tdata[VAL_W-1:0] == '0 && (st == ST_EMPTY || st == ST_FULL))
		else $error("bad status or nonzero value on a failed operation");

	// An empty report comes with a zero count, a full report with a full count.
	a_err_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (st == ST_EMPTY || st == ST_FULL) |->
			(st == ST_EMPTY && cnt == '0) || (st == ST_FULL && cnt == COUNT_W'(CAPACITY)))
		else $error("count inconsistent with status");

	// The input side is closed in the cycle after a transaction is taken.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken twice in a row");

endmodule

bind sorted_max_priority_queue smpq_check u_smpq_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import smpq_pkg::*;

	// One queue operation as the sender presents it.
	typedef struct packed {
		logic             kind;
		logic [VAL_W-1:0] value;
	} queue_op_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;   // value
	logic [0:0]        s_axis_tuser = '0;   // kind
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;        // value_out, status, count, empty_res

	// Operations waiting to be sent and results still owed by the block.
	queue_op_t ops_to_send[$];
	result_t   results_due[$];

	// Shadow copy of the sorted contents, largest first.
	logic signed [VAL_W-1:0] shadow_vals [CAPACITY];
	int shadow_held = 0;

	int errors = 0;
	int sent_cnt = 0;
	int results_seen = 0;
	int fill_level = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	queue_op_t next_op;
	result_t got;
	result_t want;

	sorted_max_priority_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one operation to the shadow queue and returns the result it owes.
	function automatic result_t predict_op(input logic kind, input logic signed [VAL_W-1:0] v);
		result_t r;
		int pos;
		int i;
		r = '0;
		r.status = ST_OK;
		if (kind == KIND_ENQ) begin
			if (shadow_held >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				// New value goes behind any equal ones already held.
				pos = shadow_held;
				while (pos > 0 && v > shadow_vals[pos-1]) begin
					shadow_vals[pos] = shadow_vals[pos-1];
					pos--;
				end
				shadow_vals[pos] = v;
				shadow_held++;
			end
		end else begin
			if (shadow_held == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.value = shadow_vals[0];
				for (i = 0; i + 1 < shadow_held; i++) begin
					shadow_vals[i] = shadow_vals[i+1];
				end
				shadow_held--;
			end
		end
		r.count = COUNT_W'(shadow_held);
		r.empty = (shadow_held == 0);
		return r;
	endfunction

	// Values biased toward extremes and tight clusters so that ties occur often.
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			5, 6: return VAL_W'(int'($urandom_range(0, 6)) - 3);
			7: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			8: begin
				if ($urandom_range(0, 1) == 0) begin
					return 32'h7FFF_FFFF - $urandom_range(0, 3);
				end else begin
					return 32'h8000_0000 + $urandom_range(0, 3);
				end
			end
			default: return $urandom;
		endcase
	endfunction

	// Queues one operation and tracks how full the block will be.
	task automatic add_op(input logic kind, input logic [VAL_W-1:0] v);
		queue_op_t op;
		op.kind = kind;
		op.value = v;
		ops_to_send.push_back(op);
		if (kind == KIND_ENQ && fill_level < CAPACITY) begin
			fill_level++;
		end else if (kind == KIND_DEQ && fill_level > 0) begin
			fill_level--;
		end
	endtask

	task automatic flag_mismatch(input string fld, input logic [VAL_W-1:0] e,
			input logic [VAL_W-1:0] a);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, fld, e, a);
		errors++;
	endtask

	// Stimulus: directed corner cases first, then fill, drain and mixed phases.
	initial begin
		add_op(KIND_DEQ, 32'hDEAD_BEEF);
		add_op(KIND_ENQ, 32'h0000_0000);
		add_op(KIND_ENQ, 32'h7FFF_FFFF);
		add_op(KIND_ENQ, 32'h8000_0000);
		add_op(KIND_ENQ, 32'hFFFF_FFFF);
		add_op(KIND_ENQ, 32'h0000_0001);
		add_op(KIND_ENQ, 32'h0000_0005);
		add_op(KIND_ENQ, 32'h0000_0005);
		add_op(KIND_ENQ, 32'h8000_0000);
		add_op(KIND_ENQ, 32'h7FFF_FFFF);
		add_op(KIND_ENQ, 32'h7FFF_FFFE);
		repeat (10) add_op(KIND_DEQ, $urandom);
		add_op(KIND_DEQ, 32'hFFFF_FFFF);
		add_op(KIND_DEQ, 32'h0000_0000);

		while (ops_to_send.size() < 1300) begin
			case ($urandom_range(0, 2))
				0: begin
					while (fill_level < CAPACITY) begin
						add_op(($urandom_range(0, 99) < 80) ? KIND_ENQ : KIND_DEQ, pick_value());
					end
					repeat ($urandom_range(1, 3)) add_op(KIND_ENQ, pick_value());
				end
				1: begin
					while (fill_level > 0) begin
						add_op(($urandom_range(0, 99) < 80) ? KIND_DEQ : KIND_ENQ, pick_value());
					end
					repeat ($urandom_range(1, 3)) add_op(KIND_DEQ, pick_value());
				end
				default: begin
					repeat (40) add_op(1'($urandom_range(0, 1)), pick_value());
				end
			endcase
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Sender: holds each transaction until it is taken, with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				sent_cnt <= sent_cnt + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (ops_to_send.size() != 0 &&
						((sent_cnt >= 500 && sent_cnt < 700) || $urandom_range(0, 99) >= 29)) begin
					next_op = ops_to_send.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= next_op.value;
					s_axis_tuser <= next_op.kind;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, one quiet window, and one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && results_seen >= 250) begin
			hold_done <= 1'b1;
			hold_left <= 400;
			m_axis_tready <= 1'b0;
		end else if (results_seen >= 500 && results_seen < 700) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= 29);
		end
	end

	// Checker: compares each result, then records what the newly taken operation owes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen <= results_seen + 1;
				got = result_t'(m_axis_tdata[RES_W-1:0]);
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h",
						$time, m_axis_tdata);
					errors++;
				end else begin
					want = results_due.pop_front();
					if (got.value !== want.value) begin
						flag_mismatch("value_out", want.value, got.value);
					end
					if (got.status !== want.status) begin
						flag_mismatch("status", VAL_W'(want.status), VAL_W'(got.status));
					end
					if (got.count !== want.count) begin
						flag_mismatch("count", VAL_W'(want.count), VAL_W'(got.count));
					end
					if (got.empty !== want.empty) begin
						flag_mismatch("empty_res", VAL_W'(want.empty), VAL_W'(got.empty));
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				results_due.push_back(predict_op(s_axis_tuser[0], s_axis_tdata[VAL_W-1:0]));
			end
		end
	end

	// End of run: everything sent and answered, then a short drain.
	initial begin
		@(posedge arst_n);
		while (ops_to_send.size() != 0 || s_axis_tvalid || results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("sorted_max_priority_queue verification clean");
		end else begin
			$display("sorted_max_priority_queue verification failed");
		end
		$finish;
	end

	initial begin
		#8000000;
		$display("%0t: timeout", $time);
		$display("sorted_max_priority_queue verification failed");
		$finish;
	end

endmodule
